// File: sv/facet_plane_coefficients_core_macros.svh
// Assertion macros shared by the facet plane coefficient RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef FACET_PLANE_COEFFICIENTS_CORE_MACROS_SVH
`define FACET_PLANE_COEFFICIENTS_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fpc_pkg.sv
// Shared widths and constants for the facet plane coefficient core.
// No dependencies.
`timescale 1ns / 1ps

package fpc_pkg;

    localparam int NORM_W     = 24;  // Q2.22 normal component
    localparam int OFFS_W     = 32;  // Q10.22 plane offset
    localparam int NORM_FRAC  = 22;
    localparam int CM_W       = 29;  // block-scaled normal magnitude
    localparam int CS_W       = 30;  // block-scaled normal, signed
    localparam int RT_W       = 30;  // square root of the scaled squared length
    localparam int SQ_W       = 2 * RT_W;
    localparam int QBASE_W    = 28;  // the length never falls below 2^QBASE_W
    localparam int OUT_DATA_W = 3 * NORM_W + OFFS_W;

    typedef logic [RT_W-1:0] root_t;

endpackage

// File: sv/fpc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
// Depends on fpc_pkg and facet_plane_coefficients_core_macros.svh.
`timescale 1ns / 1ps
`include "facet_plane_coefficients_core_macros.svh"

module fpc_div_pipe #(
    parameter int LANES  = 4,
    parameter int NUM_W  = 61,
    parameter int SIDE_W = 5
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  fpc_pkg::root_t                                den,
    input  logic [LANES*NUM_W-1:0]                        num,
    input  logic [SIDE_W-1:0]                             side_in,
    output logic                                          out_valid,
    output logic [LANES*(NUM_W-fpc_pkg::QBASE_W)-1:0]     quo,
    output logic [SIDE_W-1:0]                             side_out
);
    import fpc_pkg::*;

    localparam int Q_W = NUM_W - QBASE_W;

    logic          v_reg    [Q_W];
    root_t         den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    root_t         rem_reg  [Q_W][LANES];
    logic [Q_W-1:0] lo_reg  [Q_W][LANES];
    logic [Q_W-1:0] q_reg   [Q_W][LANES];

    genvar g, l;
    for (g = 0; g < Q_W; g++) begin : g_stage
        logic              p_v;
        root_t             p_den;
        logic [SIDE_W-1:0] p_side;

        if (g == 0) begin : g_first
            assign p_v    = in_valid;
            assign p_den  = den;
            assign p_side = side_in;
        end else begin : g_rest
            assign p_v    = v_reg[g-1];
            assign p_den  = den_reg[g-1];
            assign p_side = side_reg[g-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (adv) begin
                v_reg[g] <= p_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                den_reg[g]  <= p_den;
                side_reg[g] <= p_side;
            end
        end

        for (l = 0; l < LANES; l++) begin : g_lane
            root_t          p_rem;
            logic [Q_W-1:0] p_lo;
            logic [Q_W-1:0] p_q;
            logic [RT_W:0]  cand;
            logic           ge;

            if (g == 0) begin : g_load
                assign p_rem = RT_W'(num[l*NUM_W+Q_W +: QBASE_W]);
                assign p_lo  = num[l*NUM_W +: Q_W];
                assign p_q   = '0;
            end else begin : g_chain
                assign p_rem = rem_reg[g-1][l];
                assign p_lo  = lo_reg[g-1][l];
                assign p_q   = q_reg[g-1][l];
            end

            assign cand = {p_rem, p_lo[Q_W-1]};
            assign ge   = cand >= {1'b0, p_den};

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[g][l] <= ge ? RT_W'(cand - {1'b0, p_den}) : cand[RT_W-1:0];
                    lo_reg[g][l]  <= {p_lo[Q_W-2:0], 1'b0};
                    q_reg[g][l]   <= {p_q[Q_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];
    for (l = 0; l < LANES; l++) begin : g_out
        assign quo[l*Q_W +: Q_W] = q_reg[Q_W-1][l];
    end

    // the partial remainder stays below a non-zero divisor
    `FPC_ASSERT_IMP(a_rem_below_den, v_reg[Q_W-1] && den_reg[Q_W-1] != '0, rem_reg[Q_W-1][0] < den_reg[Q_W-1], "divider remainder not below divisor")
    // a stage holds while the pipeline is frozen
    `FPC_ASSERT_NXT(a_freeze_holds, !adv, $stable(q_reg[Q_W-1][0]), "divider output moved while frozen")

endmodule

// File: sv/facet_plane_coefficients_core.sv
// Facet plane coefficients: normalised plane equation A, B, C, D from three vertices.
// The quotient is Q_W = max(52, COORD_WIDTH+30+SHN-KSH) - 28 bits wide: 33 at defaults.
// Throughput one facet per cycle; every stage advances together when the output beat
// is taken or empty, so a stall freezes the whole pipeline and loses nothing.
// Depth is set by the 30-stage square root and the Q_W-stage divider.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "facet_plane_coefficients_core_macros.svh"

module facet_plane_coefficients_core #(
    parameter int  COORD_WIDTH     = 24,
    parameter int  COORD_FRAC_BITS = 16,
    localparam int IN_DATA_W       = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  logic [IN_DATA_W-1:0]             s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // normal_x, normal_y, normal_z, plane_offset
    output logic [fpc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // degenerate
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast
);
    import fpc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int EW    = W + 1;
    localparam int PW    = 2 * EW;
    localparam int XW    = PW + 1;
    localparam int MAG_W = XW;
    localparam int NCH   = (MAG_W + 7) / 8;
    localparam int LEN_W = $clog2(NCH * 8 + 1);
    localparam int DP_W  = CS_W + W;
    localparam int DOT_W = DP_W + 2;
    localparam int AD_W  = W + 30;
    localparam int SHN   = (COORD_FRAC_BITS < NORM_FRAC) ?
                           NORM_FRAC - COORD_FRAC_BITS + 1 : 1;
    localparam int KSH   = (COORD_FRAC_BITS > NORM_FRAC) ? COORD_FRAC_BITS - NORM_FRAC : 0;
    localparam int NO_W  = AD_W + SHN - KSH;
    localparam int NC_W  = CM_W + NORM_FRAC + 1;
    localparam int NUM_W = (NO_W > NC_W) ? NO_W : NC_W;
    localparam int Q_W   = NUM_W - QBASE_W;
    localparam int RW    = (Q_W + 1 > OFFS_W + 1) ? Q_W + 1 : OFFS_W + 1;
    localparam int SIDE_W = 5;

    typedef struct packed {
        logic [2:0][CM_W-1:0] cm;
        logic [AD_W-1:0]      ad;
        logic [2:0]           nflag;
        logic                 degen;
        logic                 last;
    } sq_side_t;

    function automatic logic [3:0] len8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) n = 4'(i + 1);
        end
        return n;
    endfunction

    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: vertices and edges
    logic signed [W-1:0]  fld [9];
    logic signed [W-1:0]  s1_p0_reg [3];
    logic signed [EW-1:0] s1_e1_reg [3], s1_e1_next [3];
    logic signed [EW-1:0] s1_e2_reg [3], s1_e2_next [3];
    logic                 s1_last_reg, v1_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) fld[i] = s_tdata[i*W +: W];
        for (int i = 0; i < 3; i++) begin
            s1_e1_next[i] = EW'(fld[3+i]) - EW'(fld[i]);
            s1_e2_next[i] = EW'(fld[6+i]) - EW'(fld[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s1_p0_reg[i] <= fld[i];
                s1_e1_reg[i] <= s1_e1_next[i];
                s1_e2_reg[i] <= s1_e2_next[i];
            end
            s1_last_reg <= s_tlast;
        end
    end

    // ---------------- stage 2: cross product partial products
    logic signed [PW-1:0] s2_pr_reg [6], s2_pr_next [6];
    logic signed [W-1:0]  s2_p0_reg [3];
    logic                 s2_last_reg, v2_reg;

    always_comb begin
        s2_pr_next[0] = s1_e1_reg[1] * s1_e2_reg[2];
        s2_pr_next[1] = s1_e2_reg[1] * s1_e1_reg[2];
        s2_pr_next[2] = s1_e2_reg[0] * s1_e1_reg[2];
        s2_pr_next[3] = s1_e1_reg[0] * s1_e2_reg[2];
        s2_pr_next[4] = s1_e1_reg[0] * s1_e2_reg[1];
        s2_pr_next[5] = s1_e2_reg[0] * s1_e1_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 6; i++) s2_pr_reg[i] <= s2_pr_next[i];
            for (int i = 0; i < 3; i++) s2_p0_reg[i] <= s1_p0_reg[i];
            s2_last_reg <= s1_last_reg;
        end
    end

    // ---------------- stage 3: exact normal
    logic signed [XW-1:0] s3_n_reg [3];
    logic signed [W-1:0]  s3_p0_reg [3];
    logic                 s3_last_reg, v3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s3_n_reg[i]  <= XW'(s2_pr_reg[2*i]) - XW'(s2_pr_reg[2*i+1]);
                s3_p0_reg[i] <= s2_p0_reg[i];
            end
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- stage 4: magnitudes and their union
    logic [MAG_W-1:0]    s4_mag_reg [3], s4_mag_next [3];
    logic [MAG_W-1:0]    s4_or_reg;
    logic [2:0]          s4_sgn_reg;
    logic signed [W-1:0] s4_p0_reg [3];
    logic                s4_last_reg, v4_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_mag_next[i] = s3_n_reg[i][XW-1] ? MAG_W'(-s3_n_reg[i]) : MAG_W'(s3_n_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s4_mag_reg[i] <= s4_mag_next[i];
                s4_sgn_reg[i] <= s3_n_reg[i][XW-1];
                s4_p0_reg[i]  <= s3_p0_reg[i];
            end
            s4_or_reg   <= s4_mag_next[0] | s4_mag_next[1] | s4_mag_next[2];
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------- stage 5: bit length per byte of the union
    logic [NCH*8-1:0]    padw;
    logic [NCH-1:0]      s5_nz_reg;
    logic [3:0]          s5_ln_reg [NCH];
    logic [MAG_W-1:0]    s5_mag_reg [3];
    logic [2:0]          s5_sgn_reg;
    logic signed [W-1:0] s5_p0_reg [3];
    logic                s5_last_reg, v5_reg;

    assign padw = (NCH*8)'(s4_or_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < NCH; c++) begin
                s5_nz_reg[c] <= |padw[c*8 +: 8];
                s5_ln_reg[c] <= len8(padw[c*8 +: 8]);
            end
            for (int i = 0; i < 3; i++) begin
                s5_mag_reg[i] <= s4_mag_reg[i];
                s5_p0_reg[i]  <= s4_p0_reg[i];
            end
            s5_sgn_reg  <= s4_sgn_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ---------------- stage 6: bit length of the largest component
    logic [LEN_W-1:0]    s6_n_reg, s6_n_next;
    logic                s6_degen_reg;
    logic [MAG_W-1:0]    s6_mag_reg [3];
    logic [2:0]          s6_sgn_reg;
    logic signed [W-1:0] s6_p0_reg [3];
    logic                s6_last_reg, v6_reg;

    always_comb begin
        s6_n_next = '0;
        for (int c = 0; c < NCH; c++) begin
            if (s5_nz_reg[c]) s6_n_next = LEN_W'(c * 8) + LEN_W'(s5_ln_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_n_reg     <= s6_n_next;
            s6_degen_reg <= ~|s5_nz_reg;
            for (int i = 0; i < 3; i++) begin
                s6_mag_reg[i] <= s5_mag_reg[i];
                s6_p0_reg[i]  <= s5_p0_reg[i];
            end
            s6_sgn_reg  <= s5_sgn_reg;
            s6_last_reg <= s5_last_reg;
        end
    end

    // ---------------- stage 7: block scaling, top bit onto bit CM_W-1
    logic [CM_W-1:0]     s7_cm_reg [3];
    logic [2:0]          s7_sgn_reg;
    logic                s7_degen_reg;
    logic signed [W-1:0] s7_p0_reg [3];
    logic                s7_last_reg, v7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s7_cm_reg[i] <= CM_W'({s6_mag_reg[i], {CM_W{1'b0}}} >> s6_n_reg);
                s7_p0_reg[i] <= s6_p0_reg[i];
            end
            s7_sgn_reg   <= s6_sgn_reg;
            s7_degen_reg <= s6_degen_reg;
            s7_last_reg  <= s6_last_reg;
        end
    end

    // ---------------- stage 8: squares and dot product terms
    logic signed [CS_W-1:0] c_s [3];
    logic [2:0]             cneg;
    logic [2*CM_W-1:0]      s8_sq_reg [3];
    logic signed [DP_W-1:0] s8_dp_reg [3];
    logic [CM_W-1:0]        s8_cm_reg [3];
    logic [2:0]             s8_cneg_reg;
    logic                   s8_degen_reg, s8_last_reg, v8_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cneg[i] = s7_sgn_reg[i] && (s7_cm_reg[i] != '0);
            c_s[i]  = cneg[i] ? -$signed({1'b0, s7_cm_reg[i]}) : $signed({1'b0, s7_cm_reg[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s8_sq_reg[i] <= s7_cm_reg[i] * s7_cm_reg[i];
                s8_dp_reg[i] <= c_s[i] * s7_p0_reg[i];
                s8_cm_reg[i] <= s7_cm_reg[i];
            end
            s8_cneg_reg  <= cneg;
            s8_degen_reg <= s7_degen_reg;
            s8_last_reg  <= s7_last_reg;
        end
    end

    // ---------------- stage 9: sums
    logic [SQ_W-1:0]         s9_sum_reg;
    logic signed [DOT_W-1:0] s9_dot_reg;
    logic [CM_W-1:0]         s9_cm_reg [3];
    logic [2:0]              s9_cneg_reg;
    logic                    s9_degen_reg, s9_last_reg, v9_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s9_sum_reg <= SQ_W'(s8_sq_reg[0]) + SQ_W'(s8_sq_reg[1]) + SQ_W'(s8_sq_reg[2]);
            s9_dot_reg <= DOT_W'(s8_dp_reg[0]) + DOT_W'(s8_dp_reg[1]) + DOT_W'(s8_dp_reg[2]);
            for (int i = 0; i < 3; i++) s9_cm_reg[i] <= s8_cm_reg[i];
            s9_cneg_reg  <= s8_cneg_reg;
            s9_degen_reg <= s8_degen_reg;
            s9_last_reg  <= s8_last_reg;
        end
    end

    // ---------------- stage 10: flip decision and offset magnitude
    logic            flip;
    logic [SQ_W-1:0] s10_sum_reg;
    sq_side_t        s10_side_reg, s10_side_next;
    logic            v10_reg;

    assign flip = s9_dot_reg[DOT_W-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s10_side_next.cm[i]    = s9_cm_reg[i];
            s10_side_next.nflag[i] = s9_cneg_reg[i] ^ flip;
        end
        // |dot| stays below 2^AD_W
        s10_side_next.ad    = flip ? AD_W'(-s9_dot_reg) : AD_W'(s9_dot_reg);
        s10_side_next.degen = s9_degen_reg;
        s10_side_next.last  = s9_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s10_sum_reg  <= s9_sum_reg;
            s10_side_reg <= s10_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (adv) begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    // ---------------- square root, one root bit per stage
    logic              sq_v_reg    [RT_W];
    logic [RT_W+1:0]   sq_rem_reg  [RT_W];
    root_t             sq_root_reg [RT_W];
    logic [SQ_W-1:0]   sq_s_reg    [RT_W];
    sq_side_t          sq_side_reg [RT_W];

    genvar g;
    for (g = 0; g < RT_W; g++) begin : g_sqrt
        logic            p_v;
        logic [RT_W+1:0] p_rem;
        root_t           p_root;
        logic [SQ_W-1:0] p_s;
        sq_side_t        p_side;
        logic [RT_W+3:0] cand, trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign p_v    = v10_reg;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_s    = s10_sum_reg;
            assign p_side = s10_side_reg;
        end else begin : g_rest
            assign p_v    = sq_v_reg[g-1];
            assign p_rem  = sq_rem_reg[g-1];
            assign p_root = sq_root_reg[g-1];
            assign p_s    = sq_s_reg[g-1];
            assign p_side = sq_side_reg[g-1];
        end

        assign cand  = {p_rem, p_s[SQ_W-1 -: 2]};
        assign trial = {2'b00, p_root, 2'b01};
        assign ge    = cand >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[g] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[g] <= p_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[g]  <= ge ? (RT_W+2)'(cand - trial) : (RT_W+2)'(cand);
                sq_root_reg[g] <= {p_root[RT_W-2:0], ge};
                sq_s_reg[g]    <= {p_s[SQ_W-3:0], 2'b00};
                sq_side_reg[g] <= p_side;
            end
        end
    end

    // ---------------- division of the four coefficients by the length
    sq_side_t              sq_out;
    logic [4*NUM_W-1:0]    div_num;
    logic [AD_W+SHN-1:0]   ad_shl;
    logic                  div_valid;
    logic [4*Q_W-1:0]      div_quo;
    logic [SIDE_W-1:0]     div_side;

    assign sq_out = sq_side_reg[RT_W-1];
    assign ad_shl = {sq_out.ad, {SHN{1'b0}}};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_num[i*NUM_W +: NUM_W] = NUM_W'({sq_out.cm[i], {(NORM_FRAC + 1){1'b0}}});
        end
        div_num[3*NUM_W +: NUM_W] = NUM_W'(ad_shl >> KSH);
    end

    fpc_div_pipe #(
        .LANES  (4),
        .NUM_W  (NUM_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_v_reg[RT_W-1]),
        .den       (sq_root_reg[RT_W-1]),
        .num       (div_num),
        .side_in   ({sq_out.nflag, sq_out.degen, sq_out.last}),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    // ---------------- rounding, sign, saturation, output register
    logic [2:0]              o_nflag;
    logic                    o_degen, o_last;
    logic [Q_W:0]            rq [3];
    logic [NORM_W-1:0]       comp [3];
    logic [RW-1:0]           ro, om;
    logic [OFFS_W-1:0]       offs;
    logic [OUT_DATA_W-1:0]   m_tdata_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg, m_tlast_reg;

    assign {o_nflag, o_degen, o_last} = div_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rq[i]   = (Q_W+1)'(div_quo[i*Q_W +: Q_W]) + (Q_W+1)'(1);
            comp[i] = o_nflag[i] ? -rq[i][NORM_W:1] : rq[i][NORM_W:1];
        end
        ro = RW'(div_quo[3*Q_W +: Q_W]) + RW'(1);
        om = ro >> 1;
        // clamp at the most negative offset
        if (om > (RW'(1) << (OFFS_W - 1))) om = RW'(1) << (OFFS_W - 1);
        offs = -om[OFFS_W-1:0];
        if (o_degen) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {offs, comp[2], comp[1], comp[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= o_degen;
            m_tlast_reg <= o_last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    `FPC_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == '0, "degenerate facet with non-zero coefficients")
    `FPC_ASSERT_IMP(a_offset_not_positive, m_tvalid, m_tdata[OUT_DATA_W-1] || (m_tdata[OUT_DATA_W-1 -: OFFS_W] == '0), "plane offset positive")
    `FPC_ASSERT_IMP(a_unit_bound, m_tvalid, (m_tdata[NORM_W-1 -: 2] != 2'b01) || (m_tdata[NORM_W-1:0] == (NORM_W'(1) << NORM_FRAC)), "normal component above one")
    `FPC_ASSERT_IMP(a_empty_accepts, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

// File: test/facet_plane_checker.sv
// Watches both channels of the facet plane coefficient core, predicts each plane beat and
// compares it field by field. Depends on fpc_pkg for the output widths.
`timescale 1ns / 1ps

module facet_plane_checker #(
    parameter int COORD_WIDTH     = 24,
    parameter int COORD_FRAC_BITS = 16,
    parameter int IN_DATA_W       = 216
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [IN_DATA_W-1:0]           s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [fpc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [0:0]                     m_tuser,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             planes_pending
);
    import fpc_pkg::*;

    typedef struct packed {
        logic [NORM_W-1:0] a;
        logic [NORM_W-1:0] b;
        logic [NORM_W-1:0] c;
        logic [OFFS_W-1:0] d;
        logic              degenerate;
        logic              last;
    } plane_t;

    plane_t planes_due[$];

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] unit_part(longint cv, logic [63:0] len, bit flip);
        logic [63:0] m;
        bit          neg;
        neg = (cv < 0) != flip;
        m   = cv < 0 ? -cv : cv;
        m   = (((m << (NORM_FRAC + 1)) / len) + 1) >> 1;
        return neg ? NORM_W'(-m) : NORM_W'(m);
    endfunction

    function automatic plane_t plane_of(logic [IN_DATA_W-1:0] data, logic last);
        longint          p [9];
        logic signed [127:0] n [3];
        logic [127:0]    mag;
        longint          cs [3];
        longint          e1 [3];
        longint          e2 [3];
        longint          dot;
        logic [63:0]     len;
        logic [127:0]    ad;
        logic [127:0]    t;
        int              nbits;
        int              bl;
        bit              flip;
        plane_t          r;
        for (int i = 0; i < 9; i++)
            p[i] = longint'($signed(data[i*COORD_WIDTH +: COORD_WIDTH]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
        end
        n[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e2[1]) * 128'(e1[2]);
        n[1] = 128'(e2[0]) * 128'(e1[2]) - 128'(e1[0]) * 128'(e2[2]);
        n[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e2[0]) * 128'(e1[1]);
        r.last       = last;
        r.degenerate = 1'b0;
        nbits = 0;
        for (int i = 0; i < 3; i++) begin
            mag = n[i] < 0 ? -n[i] : n[i];
            bl  = 0;
            for (int j = 0; j < 128; j++) if (mag[j]) bl = j + 1;
            if (bl > nbits) nbits = bl;
        end
        if (nbits == 0) begin
            r.a = '0; r.b = '0; r.c = '0; r.d = '0;
            r.degenerate = 1'b1;
            return r;
        end
        // block-scale so the top bit of the largest component lands on bit 28
        for (int i = 0; i < 3; i++) begin
            mag = n[i] < 0 ? -n[i] : n[i];
            mag = nbits > 29 ? mag >> (nbits - 29) : mag << (29 - nbits);
            cs[i] = n[i] < 0 ? -longint'(mag) : longint'(mag);
        end
        len  = floor_sqrt(64'(cs[0]*cs[0]) + 64'(cs[1]*cs[1]) + 64'(cs[2]*cs[2]));
        dot  = cs[0]*p[0] + cs[1]*p[1] + cs[2]*p[2];
        flip = dot < 0;
        ad   = dot < 0 ? 128'(-dot) : 128'(dot);
        r.a  = unit_part(cs[0], len, flip);
        r.b  = unit_part(cs[1], len, flip);
        r.c  = unit_part(cs[2], len, flip);
        if (COORD_FRAC_BITS > NORM_FRAC)
            t = (ad << 1) / (128'(len) << (COORD_FRAC_BITS - NORM_FRAC));
        else
            t = (ad << (NORM_FRAC - COORD_FRAC_BITS + 1)) / 128'(len);
        t = (t + 1) >> 1;
        if (t > (128'd1 << 31)) t = 128'd1 << 31;
        r.d = OFFS_W'(-t);
        return r;
    endfunction

    always @(posedge aclk) begin
        plane_t want;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                planes_due = {planes_due, plane_of(s_tdata, s_tlast)};
            if (m_tvalid && m_tready) begin
                if (planes_due.size() == 0) begin
                    $error("plane beat with nothing outstanding");
                    errs++;
                end else begin
                    want = planes_due.pop_front();
                    if (m_tdata[0 +: NORM_W] !== want.a) begin
                        $error("normal_x expected %h got %h", want.a, m_tdata[0 +: NORM_W]);
                        errs++;
                    end
                    if (m_tdata[NORM_W +: NORM_W] !== want.b) begin
                        $error("normal_y expected %h got %h", want.b,
                               m_tdata[NORM_W +: NORM_W]);
                        errs++;
                    end
                    if (m_tdata[2*NORM_W +: NORM_W] !== want.c) begin
                        $error("normal_z expected %h got %h", want.c,
                               m_tdata[2*NORM_W +: NORM_W]);
                        errs++;
                    end
                    if (m_tdata[3*NORM_W +: OFFS_W] !== want.d) begin
                        $error("plane_offset expected %h got %h", want.d,
                               m_tdata[3*NORM_W +: OFFS_W]);
                        errs++;
                    end
                    if (m_tuser[0] !== want.degenerate) begin
                        $error("degenerate expected %b got %b", want.degenerate, m_tuser[0]);
                        errs++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_facet_out expected %b got %b", want.last, m_tlast);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        planes_pending <= planes_due.size();
    end

endmodule

// File: test/tb.sv
// Top of the facet plane coefficient testbench: clock, reset, facet stimulus and verdict.
// Depends on fpc_pkg, facet_plane_coefficients_core and facet_plane_checker.
`timescale 1ns / 1ps

module tb;
    import fpc_pkg::*;

    localparam int CW        = 24;
    localparam int IN_DATA_W = ((9 * CW + 7) / 8) * 8;
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [0:0]              m_tuser;
    logic                    m_tlast;
    logic                    s_fire;
    int                      fail_count;
    int                      planes_pending;
    int                      phase;
    int                      send_idle_pct;
    int                      take_idle_pct;
    bit                      hold_request;
    bit                      hold_done;
    int                      hold_left;

    facet_plane_coefficients_core #(.COORD_WIDTH(CW), .COORD_FRAC_BITS(16)) i_dut (.*);

    facet_plane_checker #(.COORD_WIDTH(CW), .COORD_FRAC_BITS(16), .IN_DATA_W(IN_DATA_W))
        i_checker (.*);

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    always @(posedge aclk) s_fire <= s_tvalid && s_tready;

    // receiver: random stalls, plus one long hold-off to fill the pipeline
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = $urandom_range(0, 99) >= take_idle_pct;
            end
        end
    end

    task automatic send_facet(logic [CW-1:0] v [9], logic last);
        for (int i = 0; i < 9; i++) s_tdata[i*CW +: CW] = v[i];
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(negedge aclk); while (!s_fire);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
    endtask

    function automatic logic [CW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            default: return CW'(1);
        endcase
    endfunction

    task automatic random_facet();
        logic [CW-1:0] v [9];
        int            kind;
        int            dup;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) v[i] = CW'($urandom);
        case (kind)
            6: begin
                // small facet around a random anchor
                for (int i = 3; i < 9; i++)
                    v[i] = v[i%3] + CW'($urandom_range(0, 64)) - CW'(32);
            end
            7: begin
                // repeat a vertex: zero normal
                dup = 3 + 3 * $urandom_range(0, 1);
                for (int i = 0; i < 3; i++) v[dup + i] = v[i];
            end
            8: begin
                // collinear points: zero normal
                for (int i = 0; i < 3; i++) begin
                    v[3+i] = v[i] + CW'($urandom_range(0, 1000)) - CW'(500);
                    v[6+i] = v[i] + CW'(2) * (v[3+i] - v[i]);
                end
            end
            9: for (int i = 0; i < 9; i++) v[i] = pick_extreme();
            default: ;
        endcase
        send_facet(v, $urandom_range(0, 7) == 0);
    endtask

    initial begin
        logic [CW-1:0] v [9];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        hold_request  = 1'b0;
        send_idle_pct = 18;
        take_idle_pct = 74;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed: all zero, extremes, sign flip and a unit triangle
        foreach (v[i]) v[i] = '0;
        send_facet(v, 1'b0);
        send_facet(v, 1'b1);
        v = '{C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX};
        send_facet(v, 1'b0);
        v = '{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN};
        send_facet(v, 1'b1);
        v = '{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN};
        send_facet(v, 1'b0);
        v = '{0, 0, 0, CW'(1), 0, 0, 0, CW'(1), 0};
        send_facet(v, 1'b0);
        v = '{0, 0, CW'(65536), CW'(65536), 0, CW'(65536), 0, CW'(65536), CW'(65536)};
        send_facet(v, 1'b0);
        v = '{0, 0, CW'(-65536), CW'(65536), 0, CW'(-65536), 0, CW'(65536), CW'(-65536)};
        send_facet(v, 1'b1);
        v = '{CW'(5), CW'(5), CW'(5), CW'(5), CW'(5), CW'(5), CW'(9), CW'(9), CW'(9)};
        send_facet(v, 1'b0);
        v = '{C_MIN, 0, 0, C_MAX, 0, 0, 0, C_MAX, C_MIN};
        send_facet(v, 1'b0);
        v = '{C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX};
        send_facet(v, 1'b1);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 18 : (phase == 1 ? 74 : 0);
            take_idle_pct = phase == 0 ? 74 : (phase == 1 ? 18 : 0);
            if (phase == 2) hold_request = 1'b1;
            repeat (630) random_facet();
        end
        s_tvalid = 1'b0;

        while (planes_pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
